### rtl/skew_line_closest_approach_core_macros.svh
// Assertion macros shared by the closest-approach core.
`ifndef SKEW_LINE_CLOSEST_APPROACH_CORE_MACROS_SVH
`define SKEW_LINE_CLOSEST_APPROACH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/slca_pkg.sv
// Package with result widths, types and the parameter saturation function.
package slca_pkg;

  localparam int PARAM_W    = 40;
  localparam int PARAM_FRAC = 16;
  localparam int GAP_W      = 25;
  localparam int GAP_FRAC2  = 16;
  localparam int GAP_Q      = 2 * GAP_W;
  localparam int FRONT_LAT  = 6;

  localparam logic [PARAM_W-1:0] PARAM_POS_LIM = {1'b0, {(PARAM_W-1){1'b1}}};
  localparam logic [PARAM_W-1:0] PARAM_NEG_LIM = {1'b1, {(PARAM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [PARAM_W-1:0] pa;
    logic signed [PARAM_W-1:0] pb;
  } slca_par_t;

  // Clamp a magnitude quotient and apply the sign.
  function automatic logic [PARAM_W-1:0] sat_param(input logic [PARAM_W-1:0] q,
                                                  input logic ovf, input logic neg);
    logic [PARAM_W-1:0] lim;
    logic [PARAM_W-1:0] v;
    lim = neg ? PARAM_NEG_LIM : PARAM_POS_LIM;
    v = (ovf || (q > lim)) ? lim : q;
    return neg ? (~v + 1'b1) : v;
  endfunction

endpackage

### rtl/slca_if.sv
// Stream interfaces for line pairs in and closest-approach results out.
interface slca_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] line_a_point_x;
  logic signed [COORD_WIDTH-1:0] line_a_point_y;
  logic signed [COORD_WIDTH-1:0] line_a_point_z;
  logic signed [COORD_WIDTH-1:0] line_b_point_x;
  logic signed [COORD_WIDTH-1:0] line_b_point_y;
  logic signed [COORD_WIDTH-1:0] line_b_point_z;
  logic signed [COORD_WIDTH-1:0] line_a_dir_x;
  logic signed [COORD_WIDTH-1:0] line_a_dir_y;
  logic signed [COORD_WIDTH-1:0] line_a_dir_z;
  logic signed [COORD_WIDTH-1:0] line_b_dir_x;
  logic signed [COORD_WIDTH-1:0] line_b_dir_y;
  logic signed [COORD_WIDTH-1:0] line_b_dir_z;

  modport source (output valid, line_a_point_x, line_a_point_y, line_a_point_z,
                  line_b_point_x, line_b_point_y, line_b_point_z,
                  line_a_dir_x, line_a_dir_y, line_a_dir_z,
                  line_b_dir_x, line_b_dir_y, line_b_dir_z, input ready);
  modport sink (input valid, line_a_point_x, line_a_point_y, line_a_point_z,
                line_b_point_x, line_b_point_y, line_b_point_z,
                line_a_dir_x, line_a_dir_y, line_a_dir_z,
                line_b_dir_x, line_b_dir_y, line_b_dir_z, output ready);
endinterface

interface slca_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [slca_pkg::PARAM_W-1:0]  param_along_a;
  logic signed [slca_pkg::PARAM_W-1:0]  param_along_b;
  logic        [slca_pkg::GAP_W-1:0]    gap_length;
  logic                                 lines_parallel;

  modport source (output valid, param_along_a, param_along_b, gap_length,
                  lines_parallel, input ready);
  modport sink (input valid, param_along_a, param_along_b, gap_length,
                lines_parallel, output ready);
endinterface

### rtl/skew_line_closest_approach_core.sv
// Throughput: one line pair per cycle; the whole pipeline stalls only while a result waits.
// The latency is set by the distance path: a one-bit-per-stage squarer, a 51-stage
// divider and a 25-stage square root; the s and t dividers run in parallel and are delayed.
// Reset clears the per-stage valid bits only; no clearing pass is needed.
// Top level: closest approach parameters and shortest distance of two 3D lines.
`include "skew_line_closest_approach_core_macros.svh"

module skew_line_closest_approach_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  slca_in_if.sink  in_ch,
  slca_out_if.source out_ch
);

  localparam int W       = COORD_WIDTH;
  localparam int MW      = 3 * W + 1;
  localparam int LAT_GAP = slca_pkg::FRONT_LAT + MW + slca_pkg::GAP_Q + 1 + slca_pkg::GAP_W;
  localparam int LAT_PAR = slca_pkg::FRONT_LAT + slca_pkg::PARAM_W + 2;
  localparam int DLY     = LAT_GAP - LAT_PAR;
  localparam int LAT     = LAT_GAP + 1;

  logic                  adv;
  logic [LAT-1:0]        vld_r;
  logic signed [W-1:0]   pt_a [3];
  logic signed [W-1:0]   pt_b [3];
  logic signed [W-1:0]   dir_a [3];
  logic signed [W-1:0]   dir_b [3];
  logic [4*W:0]          mag_a;
  logic [4*W:0]          mag_b;
  logic                  neg_a;
  logic                  neg_b;
  logic [3*W:0]          mag_dc;
  logic [4*W-1:0]        c2;
  logic                  par;
  logic [slca_pkg::PARAM_W-1:0] qa;
  logic [slca_pkg::PARAM_W-1:0] qb;
  logic                  ovf_a;
  logic                  ovf_b;
  logic                  sgn_a;
  logic                  sgn_b;
  logic [2*MW-1:0]       sq;
  logic [4*W:0]          sq_side;
  logic [slca_pkg::GAP_Q-1:0] gq;
  logic                  g_ovf;
  logic                  g_par;
  logic [slca_pkg::GAP_W-1:0] root;
  logic [1:0]            rt_side;
  slca_pkg::slca_par_t   st_r;
  slca_pkg::slca_par_t   dly_r [DLY];
  logic signed [slca_pkg::PARAM_W-1:0] pa_r;
  logic signed [slca_pkg::PARAM_W-1:0] pb_r;
  logic [slca_pkg::GAP_W-1:0] gap_r;
  logic                  par_r;

  // The pipeline moves as a whole unless the result beat is held.
  assign adv         = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  assign pt_a[0]  = in_ch.line_a_point_x;
  assign pt_a[1]  = in_ch.line_a_point_y;
  assign pt_a[2]  = in_ch.line_a_point_z;
  assign pt_b[0]  = in_ch.line_b_point_x;
  assign pt_b[1]  = in_ch.line_b_point_y;
  assign pt_b[2]  = in_ch.line_b_point_z;
  assign dir_a[0] = in_ch.line_a_dir_x;
  assign dir_a[1] = in_ch.line_a_dir_y;
  assign dir_a[2] = in_ch.line_a_dir_z;
  assign dir_b[0] = in_ch.line_b_dir_x;
  assign dir_b[1] = in_ch.line_b_dir_y;
  assign dir_b[2] = in_ch.line_b_dir_z;

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  slca_front #(.W(W)) u_front (
    .clk(clk), .adv(adv), .pt_a(pt_a), .pt_b(pt_b), .dir_a(dir_a), .dir_b(dir_b),
    .mag_a(mag_a), .neg_a(neg_a), .mag_b(mag_b), .neg_b(neg_b),
    .mag_dc(mag_dc), .c2(c2), .par(par)
  );

  // Parameter dividers: |num| * 2^16 / |C|^2.
  slca_div #(.NW(4*W+1+slca_pkg::PARAM_FRAC), .DW(4*W), .QW(slca_pkg::PARAM_W), .SW(1))
  u_div_a (
    .clk(clk), .adv(adv), .num({mag_a, {slca_pkg::PARAM_FRAC{1'b0}}}), .den(c2),
    .side_in(neg_a), .quot(qa), .ovf(ovf_a), .side_out(sgn_a)
  );

  slca_div #(.NW(4*W+1+slca_pkg::PARAM_FRAC), .DW(4*W), .QW(slca_pkg::PARAM_W), .SW(1))
  u_div_b (
    .clk(clk), .adv(adv), .num({mag_b, {slca_pkg::PARAM_FRAC{1'b0}}}), .den(c2),
    .side_in(neg_b), .quot(qb), .ovf(ovf_b), .side_out(sgn_b)
  );

  // Distance path: square, scale and divide, then square root.
  slca_sq #(.MW(MW), .SW(4*W+1)) u_sq (
    .clk(clk), .adv(adv), .a(mag_dc), .side_in({par, c2}), .sq(sq), .side_out(sq_side)
  );

  slca_div #(.NW(2*MW+slca_pkg::GAP_FRAC2), .DW(4*W), .QW(slca_pkg::GAP_Q), .SW(1))
  u_div_g (
    .clk(clk), .adv(adv), .num({sq, {slca_pkg::GAP_FRAC2{1'b0}}}), .den(sq_side[4*W-1:0]),
    .side_in(sq_side[4*W]), .quot(gq), .ovf(g_ovf), .side_out(g_par)
  );

  slca_isqrt #(.RW(slca_pkg::GAP_W), .SW(2)) u_isqrt (
    .clk(clk), .adv(adv), .rad(gq), .side_in({g_par, g_ovf}), .root(root),
    .side_out(rt_side)
  );

  // Saturate s and t, then delay them to meet the distance.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r.pa  <= slca_pkg::sat_param(qa, ovf_a, sgn_a);
      st_r.pb  <= slca_pkg::sat_param(qb, ovf_b, sgn_b);
      dly_r[0] <= st_r;
    end
  end

  for (genvar i = 1; i < DLY; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // Output register: parallel lines zero both parameters and the gap.
  always_ff @(posedge clk) begin
    if (adv) begin
      par_r <= rt_side[1];
      pa_r  <= rt_side[1] ? '0 : dly_r[DLY-1].pa;
      pb_r  <= rt_side[1] ? '0 : dly_r[DLY-1].pb;
      gap_r <= rt_side[1] ? '0 : (rt_side[0] ? '1 : root);
    end
  end

  assign out_ch.valid          = vld_r[LAT-1];
  assign out_ch.param_along_a  = pa_r;
  assign out_ch.param_along_b  = pb_r;
  assign out_ch.gap_length     = gap_r;
  assign out_ch.lines_parallel = par_r;

  `SLCA_ASSERT_NOW(a_par_zero, out_ch.valid && out_ch.lines_parallel, (out_ch.param_along_a == '0) && (out_ch.param_along_b == '0) && (out_ch.gap_length == '0), "parallel result with nonzero values")
  `SLCA_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_r), "valid bits moved during a stall")
  `SLCA_ASSERT_NEXT(a_in_enters, in_ch.valid && in_ch.ready, vld_r[0], "accepted beat not tracked")

endmodule

### rtl/slca_front.sv
// Six-stage front end: difference, cross products, dot products, magnitudes.
module slca_front #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic signed [W-1:0]   pt_a [3],
  input  logic signed [W-1:0]   pt_b [3],
  input  logic signed [W-1:0]   dir_a [3],
  input  logic signed [W-1:0]   dir_b [3],
  output logic [4*W:0]          mag_a,
  output logic                  neg_a,
  output logic [4*W:0]          mag_b,
  output logic                  neg_b,
  output logic [3*W:0]          mag_dc,
  output logic [4*W-1:0]        c2,
  output logic                  par
);

  localparam int CW = 2 * W + 1;
  localparam int NW = 4 * W + 2;
  localparam int DCW = 3 * W + 2;

  logic signed [W:0]      d1_r [3];
  logic signed [W-1:0]    pa1_r [3];
  logic signed [W-1:0]    pb1_r [3];
  logic signed [2*W-1:0]  cp1_r [3][2];
  logic signed [W:0]      d2_r [3];
  logic signed [CW-1:0]   c2v_r [3];
  logic signed [CW-1:0]   mb2_r [3][2];
  logic signed [CW-1:0]   ma2_r [3][2];
  logic signed [W:0]      d3_r [3];
  logic signed [CW-1:0]   c3_r [3];
  logic signed [CW-1:0]   dpb3_r [3];
  logic signed [CW-1:0]   dpa3_r [3];
  logic signed [NW-1:0]   cc4_r [3];
  logic signed [NW-1:0]   na4_r [3];
  logic signed [NW-1:0]   nb4_r [3];
  logic signed [DCW-1:0]  dc4_r [3];
  logic signed [NW-1:0]   na5_r;
  logic signed [NW-1:0]   nb5_r;
  logic signed [DCW-1:0]  dc5_r;
  logic [NW-1:0]          c25_r;
  logic signed [NW-1:0]   abs_a;
  logic signed [NW-1:0]   abs_b;
  logic signed [DCW-1:0]  abs_dc;

  // Stages one to four work per axis.
  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk) begin
      if (adv) begin
        // Stage one: point difference and direction cross products.
        d1_r[i]     <= $signed({pt_b[i][W-1], pt_b[i]}) - $signed({pt_a[i][W-1], pt_a[i]});
        pa1_r[i]    <= dir_a[i];
        pb1_r[i]    <= dir_b[i];
        cp1_r[i][0] <= dir_a[J] * dir_b[K];
        cp1_r[i][1] <= dir_a[K] * dir_b[J];
        // Stage two: finish C and multiply D by both directions.
        d2_r[i]     <= d1_r[i];
        c2v_r[i]    <= $signed({cp1_r[i][0][2*W-1], cp1_r[i][0]})
                     - $signed({cp1_r[i][1][2*W-1], cp1_r[i][1]});
        mb2_r[i][0] <= d1_r[J] * pb1_r[K];
        mb2_r[i][1] <= d1_r[K] * pb1_r[J];
        ma2_r[i][0] <= d1_r[J] * pa1_r[K];
        ma2_r[i][1] <= d1_r[K] * pa1_r[J];
        // Stage three: finish D x PB and D x PA.
        d3_r[i]     <= d2_r[i];
        c3_r[i]     <= c2v_r[i];
        dpb3_r[i]   <= mb2_r[i][0] - mb2_r[i][1];
        dpa3_r[i]   <= ma2_r[i][0] - ma2_r[i][1];
        // Stage four: dot product terms.
        cc4_r[i]    <= c3_r[i] * c3_r[i];
        na4_r[i]    <= dpb3_r[i] * c3_r[i];
        nb4_r[i]    <= dpa3_r[i] * c3_r[i];
        dc4_r[i]    <= d3_r[i] * c3_r[i];
      end
    end
  end

  // Magnitudes for stage six.
  always_comb begin
    abs_a  = na5_r[NW-1] ? -na5_r : na5_r;
    abs_b  = nb5_r[NW-1] ? -nb5_r : nb5_r;
    abs_dc = dc5_r[DCW-1] ? -dc5_r : dc5_r;
  end

  // Stage five sums the dot products; stage six takes signs and magnitudes.
  always_ff @(posedge clk) begin
    if (adv) begin
      na5_r  <= na4_r[0] + na4_r[1] + na4_r[2];
      nb5_r  <= nb4_r[0] + nb4_r[1] + nb4_r[2];
      dc5_r  <= dc4_r[0] + dc4_r[1] + dc4_r[2];
      c25_r  <= NW'(cc4_r[0] + cc4_r[1] + cc4_r[2]);
      mag_a  <= abs_a[4*W:0];
      neg_a  <= na5_r[NW-1];
      mag_b  <= abs_b[4*W:0];
      neg_b  <= nb5_r[NW-1];
      mag_dc <= abs_dc[3*W:0];
      c2     <= c25_r[4*W-1:0];
      par    <= (c25_r == '0);
    end
  end

endmodule

### rtl/slca_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module slca_div #(
  parameter int NW = 81,
  parameter int DW = 64,
  parameter int QW = 40,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quot,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  localparam int XW = (NW > DW) ? NW : DW;

  logic [DW-1:0] rem_r  [QW+1];
  logic [QW-1:0] lo_r   [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic          ovf_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];
  logic [XW-1:0] hi;
  logic          hi_ovf;

  // Entry: the part above the quotient bits must stay below the divisor.
  always_comb begin
    hi     = XW'(num >> QW);
    hi_ovf = (hi >= XW'(den));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= hi_ovf ? '0 : hi[DW-1:0];
      lo_r[0]   <= QW'(num);
      den_r[0]  <= den;
      ovf_r[0]  <= hi_ovf;
      side_r[0] <= side_in;
    end
  end

  // One shift, compare and subtract per stage; quotient bits fill lo from below.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] rem_sh;
    logic        ge;

    always_comb begin
      rem_sh = {rem_r[k-1], lo_r[k-1][QW-1]};
      ge     = (rem_sh >= {1'b0, den_r[k-1]});
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? DW'(rem_sh - {1'b0, den_r[k-1]}) : rem_sh[DW-1:0];
        lo_r[k]   <= {lo_r[k-1][QW-2:0], ge};
        den_r[k]  <= den_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign quot     = lo_r[QW];
  assign ovf      = ovf_r[QW];
  assign side_out = side_r[QW];

endmodule

### rtl/slca_sq.sv
// Pipelined shift-and-add squarer, one multiplier bit per stage.
module slca_sq #(
  parameter int MW = 49,
  parameter int SW = 65
) (
  input  logic            clk,
  input  logic            adv,
  input  logic [MW-1:0]   a,
  input  logic [SW-1:0]   side_in,
  output logic [2*MW-1:0] sq,
  output logic [SW-1:0]   side_out
);

  localparam int PW = 2 * MW;

  logic [MW-1:0] a_r    [MW];
  logic [PW-1:0] acc_r  [MW];
  logic [SW-1:0] side_r [MW];

  for (genvar k = 0; k < MW; k++) begin : g_stage
    logic [MW-1:0] p_a;
    logic [PW-1:0] p_acc;
    logic [SW-1:0] p_side;

    // Stage zero starts from the input with an empty accumulator.
    if (k == 0) begin : g_first
      always_comb begin
        p_a    = a;
        p_acc  = '0;
        p_side = side_in;
      end
    end else begin : g_next
      always_comb begin
        p_a    = a_r[k-1];
        p_acc  = acc_r[k-1];
        p_side = side_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_r[k]    <= p_a;
        acc_r[k]  <= p_acc + (p_a[k] ? (PW'(p_a) << k) : '0);
        side_r[k] <= p_side;
      end
    end
  end

  assign sq       = acc_r[MW-1];
  assign side_out = side_r[MW-1];

endmodule

### rtl/slca_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module slca_isqrt #(
  parameter int RW = 25,
  parameter int SW = 2
) (
  input  logic            clk,
  input  logic            adv,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   side_in,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rad_r  [RW];
  logic [SW-1:0]   side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0]   p_rem;
    logic [RW-1:0]   p_root;
    logic [2*RW-1:0] p_rad;
    logic [SW-1:0]   p_side;
    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      always_comb begin
        p_rem  = '0;
        p_root = '0;
        p_rad  = rad;
        p_side = side_in;
      end
    end else begin : g_next
      always_comb begin
        p_rem  = rem_r[k-1];
        p_root = root_r[k-1];
        p_rad  = rad_r[k-1];
        p_side = side_r[k-1];
      end
    end

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      rem_sh = {p_rem, p_rad[2*RW-1 -: 2]};
      trial  = {2'b00, p_root, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
        root_r[k] <= {p_root[RW-2:0], ge};
        rad_r[k]  <= {p_rad[2*RW-3:0], 2'b00};
        side_r[k] <= p_side;
      end
    end
  end

  assign root     = root_r[RW-1];
  assign side_out = side_r[RW-1];

endmodule
